// File: rtl/core/lphd_pkg.sv
// Types, phase codes and field role codes shared by the header decoder modules.
package lphd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [7:0]  byte_out;
    logic        frame_done;
    logic        frame_status;
    logic [17:0] header_length;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_GLEN_HI = 4'd0,
    PH_GLEN_LO = 4'd1,
    PH_GFIELD  = 4'd2,
    PH_SLEN_HI = 4'd3,
    PH_SLEN_LO = 4'd4,
    PH_SFIELD  = 4'd5,
    PH_DLEN_HI = 4'd6,
    PH_DLEN_LO = 4'd7,
    PH_DFIELD  = 4'd8,
    PH_PAYLOAD = 4'd9
  } phase_t;

  localparam logic [2:0] KIND_GROUP_LEN  = 3'd0;
  localparam logic [2:0] KIND_GROUP_BYTE = 3'd1;
  localparam logic [2:0] KIND_SRC_LEN    = 3'd2;
  localparam logic [2:0] KIND_SRC_BYTE   = 3'd3;
  localparam logic [2:0] KIND_DST_LEN    = 3'd4;
  localparam logic [2:0] KIND_DST_BYTE   = 3'd5;
  localparam logic [2:0] KIND_PAYLOAD    = 3'd6;

  localparam logic       STATUS_OK        = 1'b0;
  localparam logic       STATUS_TRUNCATED = 1'b1;

  localparam logic [7:0] MIN_FRAME_LENGTH_RESET = 8'd2;

  function automatic logic [2:0] kind_of_phase(input phase_t phase);
    logic [2:0] kind;
    case (phase)
      PH_GLEN_HI, PH_GLEN_LO: kind = KIND_GROUP_LEN;
      PH_GFIELD:              kind = KIND_GROUP_BYTE;
      PH_SLEN_HI, PH_SLEN_LO: kind = KIND_SRC_LEN;
      PH_SFIELD:              kind = KIND_SRC_BYTE;
      PH_DLEN_HI, PH_DLEN_LO: kind = KIND_DST_LEN;
      PH_DFIELD:              kind = KIND_DST_BYTE;
      default:                kind = KIND_PAYLOAD;
    endcase
    return kind;
  endfunction

endpackage

// File: rtl/core/lphd_parser.sv
// Frame parsing state and the per-byte role, status and header length logic.
module lphd_parser import lphd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  input  logic [7:0] min_frame_length,
  output out_item_t  result
);

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] bytes_remaining;
  logic [15:0] bytes_remaining_next;
  logic [7:0]  length_high_byte;
  logic [7:0]  length_high_byte_next;
  logic [17:0] header_count;
  logic [17:0] header_count_next;
  logic [7:0]  total_count;
  logic [7:0]  total_count_next;
  logic        frame_ok;

  always_comb begin
    phase_next            = phase;
    bytes_remaining_next  = bytes_remaining;
    length_high_byte_next = length_high_byte;
    header_count_next     = (phase != PH_PAYLOAD) ? header_count + 18'd1 : header_count;
    total_count_next      = (total_count != 8'hFF) ? total_count + 8'd1 : total_count;

    case (phase) inside
      PH_GLEN_HI, PH_SLEN_HI, PH_DLEN_HI: begin
        length_high_byte_next = item.data_byte;
        phase_next            = phase_t'(phase + 4'd1);
      end
      PH_GLEN_LO, PH_SLEN_LO, PH_DLEN_LO: begin
        bytes_remaining_next = {length_high_byte, item.data_byte};
        phase_next = (bytes_remaining_next != 16'd0) ? phase_t'(phase + 4'd1)
                                                     : phase_t'(phase + 4'd2);
      end
      PH_GFIELD, PH_SFIELD, PH_DFIELD: begin
        bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining_next == 16'd0) begin
          phase_next = phase_t'(phase + 4'd1);
        end
      end
      default: begin
        phase_next = PH_PAYLOAD;
      end
    endcase

    frame_ok = (phase_next == PH_PAYLOAD) && (total_count_next >= min_frame_length);

    result.field_kind    = kind_of_phase(phase);
    result.byte_out      = item.data_byte;
    result.frame_done    = item.is_last;
    result.frame_status  = STATUS_OK;
    result.header_length = 18'd0;
    if (item.is_last) begin
      result.frame_status  = frame_ok ? STATUS_OK : STATUS_TRUNCATED;
      result.header_length = frame_ok ? header_count_next : 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_GLEN_HI;
      bytes_remaining  <= 16'd0;
      length_high_byte <= 8'd0;
      header_count     <= 18'd0;
      total_count      <= 8'd0;
    end else if (step) begin
      if (item.is_last) begin
        phase            <= PH_GLEN_HI;
        bytes_remaining  <= 16'd0;
        length_high_byte <= 8'd0;
        header_count     <= 18'd0;
        total_count      <= 8'd0;
      end else begin
        phase            <= phase_next;
        bytes_remaining  <= bytes_remaining_next;
        length_high_byte <= length_high_byte_next;
        header_count     <= header_count_next;
        total_count      <= total_count_next;
      end
    end
  end

endmodule

// File: rtl/core/length_prefixed_header_decoder_core.sv
// Top level of the length-prefixed header decoder: input register, parser and result register.
// Each request carries one message byte; the block tags it with its role (group, source or
// destination length or byte, or payload) and, on the byte marked last, reports ok or
// truncated and, when ok, the number of header bytes ahead of the payload. A request is
// registered on acceptance, parsed as it leaves the input register and its result held in an
// output register, so one request is taken every cycle as long as results are taken. The
// minimum frame length register should be written only while no request is in flight.
module length_prefixed_header_decoder_core import lphd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  logic       s1_valid;
  in_item_t   s1_item;
  logic       s1_move;
  logic [7:0] min_frame_length;
  out_item_t  result;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  lphd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (s1_move),
    .item             (s1_item),
    .min_frame_length (min_frame_length),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      min_frame_length <= MIN_FRAME_LENGTH_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        min_frame_length <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
    if (s1_move) begin
      out_data <= result;
    end
  end

endmodule

// File: tb/tb_length_prefixed_header_decoder_core.sv
// Self-checking testbench for the length-prefixed header decoder core.
`timescale 1ns / 1ps

module tb_length_prefixed_header_decoder_core;
  import lphd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = '0;

  // Decoder state as predicted from the accepted requests.
  phase_t      parse_phase = PH_GLEN_HI;
  logic [15:0] bytes_left = '0;
  logic [7:0]  length_hi = '0;
  logic [17:0] header_count = '0;
  logic [7:0]  frame_count = '0;
  logic [7:0]  min_length = MIN_FRAME_LENGTH_RESET;

  out_item_t   pending_results[$];
  logic [7:0]  frame_q[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;

  length_prefixed_header_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic decode_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    phase_t ph;
    logic ok;
    ph = parse_phase;
    r = '0;
    r.byte_out = b;
    case (ph)
      PH_GLEN_HI, PH_GLEN_LO: r.field_kind = KIND_GROUP_LEN;
      PH_GFIELD:              r.field_kind = KIND_GROUP_BYTE;
      PH_SLEN_HI, PH_SLEN_LO: r.field_kind = KIND_SRC_LEN;
      PH_SFIELD:              r.field_kind = KIND_SRC_BYTE;
      PH_DLEN_HI, PH_DLEN_LO: r.field_kind = KIND_DST_LEN;
      PH_DFIELD:              r.field_kind = KIND_DST_BYTE;
      default:                r.field_kind = KIND_PAYLOAD;
    endcase
    if (ph != PH_PAYLOAD) header_count = header_count + 18'd1;
    if (frame_count != 8'hFF) frame_count = frame_count + 8'd1;
    case (ph)
      PH_GLEN_HI, PH_SLEN_HI, PH_DLEN_HI: begin
        length_hi = b;
        ph = phase_t'(ph + 4'd1);
      end
      PH_GLEN_LO, PH_SLEN_LO, PH_DLEN_LO: begin
        bytes_left = {length_hi, b};
        ph = phase_t'(ph + ((bytes_left != 16'd0) ? 4'd1 : 4'd2));
      end
      PH_GFIELD, PH_SFIELD, PH_DFIELD: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) ph = phase_t'(ph + 4'd1);
      end
      default: ph = PH_PAYLOAD;
    endcase
    parse_phase = ph;
    if (last) begin
      ok = (ph == PH_PAYLOAD) && (frame_count >= min_length);
      r.frame_done = 1'b1;
      r.frame_status = ok ? STATUS_OK : STATUS_TRUNCATED;
      r.header_length = ok ? header_count : 18'd0;
      parse_phase = PH_GLEN_HI;
      bytes_left = '0;
      length_hi = '0;
      header_count = '0;
      frame_count = '0;
    end
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, byte_out", out_data.byte_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.field_kind != want.field_kind)
          report_mismatch("field_kind", out_data.field_kind, want.field_kind);
        if (out_data.byte_out != want.byte_out)
          report_mismatch("byte_out", out_data.byte_out, want.byte_out);
        if (out_data.frame_done != want.frame_done)
          report_mismatch("frame_done", out_data.frame_done, want.frame_done);
        if (out_data.frame_status != want.frame_status)
          report_mismatch("frame_status", out_data.frame_status, want.frame_status);
        if (out_data.header_length != want.header_length)
          report_mismatch("header_length", out_data.header_length, want.header_length);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("length_prefixed_header_decoder_core: mismatch");
        $finish;
      end
    end
  end

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic void push_field(input int len);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    repeat (len) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void build_frame(input int glen, input int slen, input int dlen,
                                      input int plen);
    frame_q.delete();
    push_field(glen);
    push_field(slen);
    push_field(dlen);
    repeat (plen) frame_q.push_back(8'($urandom));
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_min_length(input logic [7:0] value);
    wait_idle();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    min_length = value;
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 3) == 0) return $urandom_range(5, 12);
    return $urandom_range(0, 4);
  endfunction

  // Mostly well-formed frames, some cut short, and some random noise.
  task automatic run_random(input int n_items);
    int goal;
    int pick;
    int keep;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        frame_q.delete();
        repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
      end else begin
        build_frame(pick_length(), pick_length(), pick_length(), $urandom_range(0, 6));
        if (pick <= 2) begin
          keep = $urandom_range(1, frame_q.size());
          while (frame_q.size() > keep) void'(frame_q.pop_back());
        end
      end
      send_frame_q();
    end
  endtask

  task automatic test_directed_frames();
    // All three fields empty and no payload.
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame_q();
    // A frame that ends in the first length.
    send_byte(8'hFF, 1'b1);
    // A frame that ends inside the group field.
    frame_q = '{8'h00, 8'h02, 8'hAA};
    send_frame_q();
    // One-byte fields followed by one payload byte.
    frame_q = '{8'h00, 8'h01, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h80, 8'hFF};
    send_frame_q();
  endtask

  task automatic test_min_length_zero();
    set_min_length(8'd0);
    run_random(400);
  endtask

  task automatic test_long_frames();
    set_min_length(8'd255);
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame_q();
    build_frame(16'h0110, 0, 3, 5);
    send_frame_q();
    build_frame(16'h0100, 2, 1, 0);
    while (frame_q.size() > 260) void'(frame_q.pop_back());
    send_frame_q();
    run_random(150);
  endtask

  task automatic test_mid_min_length();
    set_min_length(8'($urandom_range(1, 40)));
    run_random(400);
  endtask

  task automatic test_no_idling();
    set_min_length(MIN_FRAME_LENGTH_RESET);
    idle_on = 1'b0;
    run_random(300);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_min_length_zero();
    test_long_frames();
    test_mid_min_length();
    test_no_idling();
    wait_idle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("length_prefixed_header_decoder_core: match");
    end else begin
      $display("length_prefixed_header_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lphd_pkg.sv
rtl/core/lphd_parser.sv
rtl/core/length_prefixed_header_decoder_core.sv
tb/tb_length_prefixed_header_decoder_core.sv
